// File: rtl/edfs_pkg.sv
// edfs_pkg: shared types and codes for the edf process scheduler
// no dependencies
package edfs_pkg;

	typedef enum logic [1:0] {
		OP_CREATE_NORMAL = 2'd0,
		OP_CREATE_RT     = 2'd1,
		OP_TICK          = 2'd2,
		OP_SELECT        = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_WAITING = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	localparam int unsigned CNT_W  = 32;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned IN_W   = 72;
	localparam int unsigned OUT_W  = 72;

endpackage

// File: rtl/edfs_ram.sv
// edfs_ram: generic single write port ram with registered read
// no dependencies
module edfs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/edfs_cmp.sv
// edfs_cmp: shared unsigned time comparator used by the sequencer
// no dependencies
module edfs_cmp #(
	parameter int unsigned TW = 32
) (
	input  logic [TW-1:0] a,
	input  logic [TW-1:0] b,
	output logic          lt,
	output logic          le
);
	assign lt = a < b;
	assign le = a <= b;
endmodule

// File: rtl/edf_process_scheduler_top.sv
// edf_process_scheduler_top: earliest deadline first scheduler with round-robin fallback
// depends on edfs_pkg, edfs_ram, edfs_cmp
//
// channel  dir  tdata (low bit up)
// s_axis   in   opcode[1:0] start_ms[33:2] relative_deadline_ms[65:34] current_finished[66]
// m_axis   out  status[1:0] slot[5:2] slot_valid[6] is_realtime[7] met[39:8] missed[71:40]
//
// select makes two passes over all slots, with a read and a check state per slot
// after each result transfer the scheduler returns to idle before the next accept
// the time ram read port is shared by one comparator, one slot per pass step
// no clearing pass after reset; slot flags clear at once
// s_axis_tready is low while an item is in work or a result waits
module edf_process_scheduler_top
	import edfs_pkg::*;
#(
	parameter int unsigned SLOTS      = 16,
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,   // opcode, start_ms, relative_deadline_ms, current_finished
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata    // status, slot, slot_valid, is_realtime, met, missed
);
	localparam int unsigned SW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_REL_RD, S_REL_CHK, S_RUN_RD, S_RUN_CHK,
		S_BEST_RD, S_BEST_CHK, S_Q_RD, S_Q_WR, S_Q_HEAD, S_Q_OUT, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0]            op_q;
	logic [TIME_WIDTH-1:0] start_q, rel_q;
	logic                  fin_q;
	logic [SLOTS-1:0]      used_q, rt_q, relsd_q;
	logic [SW-1:0]         head_q, idx_q, best_q, run_q;
	logic [CW-1:0]         cnt_q;
	logic [TIME_WIDTH-1:0] now_q, bestdl_q;
	logic                  run_v_q, best_v_q, pend_q, rotate_q;
	logic [CNT_W-1:0]      met_q, missed_q;
	logic [1:0]            st_q;
	logic [SW-1:0]         oslot_q;
	logic                  ov_q, ort_q;

	logic [SW-1:0]         free_idx;
	logic                  free_found;
	always_comb begin
		free_idx = '0;
		free_found = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SW'(i);
				free_found = 1'b1;
			end
		end
	end

	// time rams: release time and deadline; normal queue ram
	logic                  t_we;
	logic [SW-1:0]         t_waddr, t_raddr;
	logic [TIME_WIDTH-1:0] rel_rd, dl_rd, dl_wdata;
	logic                  q_we;
	logic [SW-1:0]         q_waddr, q_raddr, q_wdata, q_rd;

	assign dl_wdata = start_q + rel_q;
	assign t_we     = (state_q == S_DECODE) && (op_q == OP_CREATE_RT) && free_found;
	assign t_waddr  = free_idx;

	edfs_ram #(.WIDTH(TIME_WIDTH), .DEPTH(SLOTS)) u_rel (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(start_q),
		.raddr(t_raddr), .rdata(rel_rd));
	edfs_ram #(.WIDTH(TIME_WIDTH), .DEPTH(SLOTS)) u_dl (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(dl_wdata),
		.raddr(t_raddr), .rdata(dl_rd));
	edfs_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_q (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rd));

	logic [SW:0] tail_sum;
	logic [SW-1:0] tail_idx;
	assign tail_sum = {1'b0, head_q} + (SW+1)'(cnt_q);
	assign tail_idx = (tail_sum >= (SW+1)'(SLOTS)) ? SW'(tail_sum - (SW+1)'(SLOTS))
		: SW'(tail_sum);
	logic [SW-1:0] head_nx;
	assign head_nx = (head_q == LAST) ? '0 : head_q + 1'b1;
	// rotation writes the old head at head+cnt while head advances
	always_comb begin
		q_we = 1'b0;
		q_waddr = tail_idx;
		q_wdata = free_idx;
		if (state_q == S_DECODE && op_q == OP_CREATE_NORMAL && free_found
				&& cnt_q < CW'(SLOTS)) begin
			q_we = 1'b1;
		end else if (state_q == S_Q_HEAD && rotate_q) begin
			q_we = 1'b1;
			q_wdata = q_rd;
		end
	end
	assign q_raddr = head_q;

	always_comb begin
		case (state_q)
			S_RUN_RD: t_raddr = run_q;
			default:  t_raddr = idx_q;
		endcase
	end

	// shared comparator
	logic [TIME_WIDTH-1:0] ca, cb;
	logic c_lt, c_le;
	always_comb begin
		case (state_q)
			S_REL_CHK: begin ca = rel_rd; cb = now_q; end
			S_RUN_CHK: begin ca = dl_rd;  cb = now_q; end
			default:   begin ca = dl_rd;  cb = bestdl_q; end
		endcase
	end
	edfs_cmp #(.TW(TIME_WIDTH)) u_cmp (.a(ca), .b(cb), .lt(c_lt), .le(c_le));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0; rt_q <= '0; relsd_q <= '0;
			head_q <= '0; cnt_q <= '0; now_q <= '0;
			run_q <= '0; run_v_q <= 1'b0;
			met_q <= '0; missed_q <= '0;
			idx_q <= '0; best_q <= '0; best_v_q <= 1'b0; pend_q <= 1'b0;
			rotate_q <= 1'b0; bestdl_q <= '0;
			st_q <= '0; oslot_q <= '0; ov_q <= 1'b0; ort_q <= 1'b0;
			op_q <= '0; start_q <= '0; rel_q <= '0; fin_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tdata[1:0];
						start_q <= TIME_WIDTH'(s_axis_tdata[33:2]);
						rel_q   <= TIME_WIDTH'(s_axis_tdata[65:34]);
						fin_q   <= s_axis_tdata[66];
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					st_q <= ST_OK; oslot_q <= '0; ov_q <= 1'b0; ort_q <= 1'b0;
					state_q <= S_OUT;
					case (op_q)
						OP_CREATE_NORMAL, OP_CREATE_RT: begin
							if (!free_found) begin
								st_q <= ST_FULL;
							end else begin
								used_q[free_idx]  <= 1'b1;
								relsd_q[free_idx] <= 1'b0;
								rt_q[free_idx]    <= (op_q == OP_CREATE_RT);
								if (op_q == OP_CREATE_NORMAL && cnt_q < CW'(SLOTS)) begin
									cnt_q <= cnt_q + 1'b1;
								end
								oslot_q <= free_idx; ov_q <= 1'b1;
								ort_q <= (op_q == OP_CREATE_RT);
							end
						end
						OP_TICK: now_q <= now_q + 1'b1;
						default: begin
							idx_q <= '0;
							state_q <= S_REL_RD;
						end
					endcase
				end
				S_REL_RD: state_q <= S_REL_CHK;
				S_REL_CHK: begin
					if (used_q[idx_q] && rt_q[idx_q] && !relsd_q[idx_q] && c_le) begin
						relsd_q[idx_q] <= 1'b1;
					end
					if (idx_q == LAST) begin
						state_q <= S_RUN_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_REL_RD;
					end
				end
				S_RUN_RD: state_q <= S_RUN_CHK;
				S_RUN_CHK: begin
					rotate_q <= 1'b0;
					if (run_v_q) begin
						if (rt_q[run_q]) begin
							if (fin_q) begin
								if (c_le) missed_q <= missed_q + 1'b1;
								else      met_q <= met_q + 1'b1;
								used_q[run_q] <= 1'b0; rt_q[run_q] <= 1'b0;
								relsd_q[run_q] <= 1'b0;
							end
						end else if (fin_q) begin
							used_q[run_q] <= 1'b0; rt_q[run_q] <= 1'b0;
							relsd_q[run_q] <= 1'b0;
							if (cnt_q != '0) begin
								head_q <= head_nx;
								cnt_q <= cnt_q - 1'b1;
							end
						end else begin
							rotate_q <= 1'b1;
						end
						run_v_q <= 1'b0;
					end
					idx_q <= '0; best_v_q <= 1'b0; pend_q <= 1'b0;
					state_q <= S_BEST_RD;
				end
				S_BEST_RD: state_q <= S_BEST_CHK;
				S_BEST_CHK: begin
					if (used_q[idx_q] && rt_q[idx_q]) begin
						if (!relsd_q[idx_q]) begin
							pend_q <= 1'b1;
						end else if (!best_v_q || c_lt) begin
							best_v_q <= 1'b1; best_q <= idx_q; bestdl_q <= dl_rd;
						end
					end
					if (idx_q == LAST) begin
						state_q <= S_Q_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_BEST_RD;
					end
				end
				S_Q_RD: begin
					if (best_v_q) begin
						run_q <= best_q; run_v_q <= 1'b1;
						oslot_q <= best_q; ov_q <= 1'b1; ort_q <= 1'b1;
						state_q <= S_OUT;
					end else if (cnt_q == '0) begin
						st_q <= pend_q ? ST_WAITING : ST_IDLE;
						state_q <= S_OUT;
					end else begin
						state_q <= S_Q_HEAD;
					end
				end
				S_Q_HEAD: begin
					if (rotate_q) begin
						head_q <= head_nx;
						state_q <= S_Q_WR;
					end else begin
						run_q <= q_rd; run_v_q <= 1'b1;
						oslot_q <= q_rd; ov_q <= 1'b1;
						state_q <= S_OUT;
					end
				end
				S_Q_WR: begin
					rotate_q <= 1'b0;
					state_q <= S_Q_OUT;
				end
				S_Q_OUT: state_q <= S_Q_HEAD;
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {missed_q, met_q, ort_q, ov_q,
		SLOT_W'({{SLOT_W{1'b0}}, oslot_q}), st_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		run_v_q |-> used_q[run_q]) else $error("running slot not in use");
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(SLOTS)) else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(relsd_q & ~(used_q & rt_q)) == '0) else $error("released flag on non rt slot");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_axis_tvalid) |=> state_q == S_DECODE)
		else $error("accepted transfer not decoded");
endmodule
